// ----- hdl/imu_gbc_pkg.sv -----
package imu_gbc_pkg;

    localparam int AxisW  = 16;
    localparam int CfgW   = 23;
    localparam int IdxW   = 3;
    localparam int NormSumW = 32;
    localparam int GyroSumW = 33;
    localparam int MagW   = 33;
    localparam int DivW   = 41;
    localparam int OutW   = 24;

    localparam logic [IdxW-1:0] REG_SAMPLE_COUNT      = 3'd0;
    localparam logic [IdxW-1:0] REG_NORM_SPREAD_LIMIT = 3'd1;
    localparam logic [IdxW-1:0] REG_GYRO_SPREAD_LIMIT = 3'd2;
    localparam logic [IdxW-1:0] REG_NORM_TARGET       = 3'd3;
    localparam logic [IdxW-1:0] REG_NORM_TOLERANCE    = 3'd4;
    localparam logic [IdxW-1:0] REG_BIAS_LIMIT        = 3'd5;

    localparam logic [15:0] RST_SAMPLE_COUNT      = 16'd6000;
    localparam logic [15:0] RST_NORM_SPREAD_LIMIT = 16'd390;
    localparam logic [15:0] RST_GYRO_SPREAD_LIMIT = 16'd141;
    localparam logic [15:0] RST_NORM_TARGET       = 16'd5461;
    localparam logic [15:0] RST_NORM_TOLERANCE    = 16'd279;
    localparam logic [22:0] RST_BIAS_LIMIT        = 23'd2403;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQR  = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_CHK  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    typedef logic signed [15:0] axis_t;

endpackage

// ----- hdl/imu_gyro_bias_calibrator.sv -----
// IMU stationary gyro bias calibrator.
// Input channel (in_valid/in_ready) takes one raw IMU request per sample:
// three accel axes, three gyro axes and gyro_ok. Samples with gyro_ok low
// reuse the last valid gyro values for the spread checks and add nothing to
// the gyro sums. The accel norm is the integer square root of the sum of
// squares.
// A window ends after sample_count samples, or early when a norm or gyro
// spread exceeds its limit. At window end one result leaves on the output
// channel (out_valid/out_ready): pass flag, early-abort flag, three gyro
// biases and the mean norm, all Q.8, rounded to nearest.
// Steps: a sample that does not end a window is squared axis by axis on the
// shared multiplier, passes 16 square-root steps and an update, and returns
// to idle. A window end adds an operand load, four times 41 divider steps
// and a check, and an output step; the shared divider makes one quotient bit
// per cycle.
// The result sits in an output register; while the receiver stalls the
// block keeps accepting samples, and stops only when a second result is
// ready before the first is taken.
// Reset restores the default configuration, clears the window and the
// last gyro values. Config writes (cfg_write/cfg_index/cfg_data) act at
// once and must come while the block is idle.
module imu_gyro_bias_calibrator
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [22:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  accel_x,
    input  logic signed [15:0]  accel_y,
    input  logic signed [15:0]  accel_z,
    input  logic signed [15:0]  gyro_x,
    input  logic signed [15:0]  gyro_y,
    input  logic signed [15:0]  gyro_z,
    input  logic                gyro_ok,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                passed,
    output logic                aborted_early,
    output logic signed [23:0]  bias_x,
    output logic signed [23:0]  bias_y,
    output logic signed [23:0]  bias_z,
    output logic [23:0]         mean_norm
);

    localparam logic [2:0] ST_CHK_NEXT = imu_gbc_pkg::ST_CHK;
    localparam logic [2:0] ST_IDLE = imu_gbc_pkg::ST_IDLE;
    localparam logic [2:0] ST_SQR  = imu_gbc_pkg::ST_SQR;
    localparam logic [2:0] ST_ROOT = imu_gbc_pkg::ST_ROOT;
    localparam logic [2:0] ST_UPD  = imu_gbc_pkg::ST_UPD;
    localparam logic [2:0] ST_DIV  = imu_gbc_pkg::ST_DIV;
    localparam logic [2:0] ST_OUT  = imu_gbc_pkg::ST_OUT;

    logic [15:0] sample_count_reg, norm_spread_reg, gyro_spread_reg;
    logic [15:0] norm_target_reg, norm_tol_reg;
    logic [22:0] bias_limit_reg;

    logic [2:0]  state_reg;
    logic [5:0]  cnt_reg;
    imu_gbc_pkg::axis_t acc_reg [3];
    imu_gbc_pkg::axis_t gin_reg [3];
    logic        gok_reg;

    logic [31:0] v_reg, res_reg, bit_reg;

    logic [15:0] idx_reg;
    logic [31:0] norm_sum_reg;
    logic signed [32:0] gsum_reg [3];
    logic [15:0] nmax_reg, nmin_reg;
    imu_gbc_pkg::axis_t gmax_reg [3];
    imu_gbc_pkg::axis_t gmin_reg [3];
    imu_gbc_pkg::axis_t last_reg [3];

    logic [1:0]  k_reg;
    logic [16:0] rem_reg;
    logic [40:0] dq_reg;
    logic        neg_reg;
    logic        abort_reg, pass_reg;
    logic [23:0] mean_reg;
    logic [23:0] bias_reg [3];

    logic        out_valid_reg, passed_reg, abort_out_reg;
    logic [23:0] bias_out_reg [3];
    logic [23:0] mean_out_reg;

    logic [15:0] den;
    assign den = (sample_count_reg == 16'd0) ? 16'd1 : sample_count_reg;

    imu_gbc_pkg::axis_t acc_sel;
    logic signed [31:0] prod;
    assign acc_sel = acc_reg[cnt_reg[1:0]];
    assign prod    = acc_sel * acc_sel;

    logic [31:0] trial;
    assign trial = res_reg + bit_reg;

    logic [15:0] norm;
    logic [15:0] nmax_new, nmin_new;
    imu_gbc_pkg::axis_t lg_new [3];
    imu_gbc_pkg::axis_t gmax_new [3];
    imu_gbc_pkg::axis_t gmin_new [3];
    logic        abort_now;
    logic [16:0] idx_plus;
    logic        done;
    logic signed [16:0] gspread [3];

    always_comb
    begin
        norm = res_reg[15:0];
        if (idx_reg == 16'd0)
        begin
            nmax_new = norm;
            nmin_new = norm;
        end
        else
        begin
            nmax_new = (norm > nmax_reg) ? norm : nmax_reg;
            nmin_new = (norm < nmin_reg) ? norm : nmin_reg;
        end
        abort_now = (nmax_new - nmin_new) > norm_spread_reg;
        for (int k = 0; k < 3; k++)
        begin
            lg_new[k] = gok_reg ? gin_reg[k] : last_reg[k];
            if (idx_reg == 16'd0)
            begin
                gmax_new[k] = lg_new[k];
                gmin_new[k] = lg_new[k];
            end
            else
            begin
                gmax_new[k] = (lg_new[k] > gmax_reg[k]) ? lg_new[k] : gmax_reg[k];
                gmin_new[k] = (lg_new[k] < gmin_reg[k]) ? lg_new[k] : gmin_reg[k];
            end
            gspread[k] = 17'(gmax_new[k]) - 17'(gmin_new[k]);
            if (gspread[k][15:0] > gyro_spread_reg)
                abort_now = 1'b1;
        end
        idx_plus = {1'b0, idx_reg} + 17'd1;
        done = abort_now || (idx_plus >= {1'b0, den});
    end

    // divider operand select
    logic [1:0]  ksel;
    logic [32:0] mag;
    logic        mag_neg;
    logic signed [32:0] gs_sel;
    logic [40:0] dividend;

    always_comb
    begin
        gs_sel = gsum_reg[0];
        mag_neg = 1'b0;
        if (ksel == 2'd0)
            mag = {1'b0, norm_sum_reg};
        else
        begin
            gs_sel  = gsum_reg[ksel - 2'd1];
            mag_neg = gs_sel[32];
            mag     = mag_neg ? 33'(-gs_sel) : 33'(gs_sel);
        end
        dividend = {mag, 8'd0} + 41'(den[15:1]);
    end

    logic [16:0] rem_sh;
    logic        rem_ge;
    assign rem_sh = {rem_reg[15:0], dq_reg[40]};
    assign rem_ge = rem_sh >= {1'b0, den};

    logic signed [41:0] mdiff;
    logic [41:0] mabs;
    logic        chk_fail;
    always_comb
    begin
        mdiff = $signed({1'b0, dq_reg}) - $signed({18'd0, norm_target_reg, 8'd0});
        mabs  = mdiff[41] ? 42'(-mdiff) : 42'(mdiff);
        if (k_reg == 2'd0)
            chk_fail = mabs > {18'd0, norm_tol_reg, 8'd0};
        else
            chk_fail = dq_reg > {18'd0, bias_limit_reg};
    end

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;
    assign ksel = (state_reg == ST_CHK_NEXT && cnt_reg != 6'd63) ? (k_reg + 2'd1)
                                                                : 2'd0;

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= imu_gbc_pkg::RST_SAMPLE_COUNT;
            norm_spread_reg  <= imu_gbc_pkg::RST_NORM_SPREAD_LIMIT;
            gyro_spread_reg  <= imu_gbc_pkg::RST_GYRO_SPREAD_LIMIT;
            norm_target_reg  <= imu_gbc_pkg::RST_NORM_TARGET;
            norm_tol_reg     <= imu_gbc_pkg::RST_NORM_TOLERANCE;
            bias_limit_reg   <= imu_gbc_pkg::RST_BIAS_LIMIT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                imu_gbc_pkg::REG_SAMPLE_COUNT:      sample_count_reg <= cfg_data[15:0];
                imu_gbc_pkg::REG_NORM_SPREAD_LIMIT: norm_spread_reg  <= cfg_data[15:0];
                imu_gbc_pkg::REG_GYRO_SPREAD_LIMIT: gyro_spread_reg  <= cfg_data[15:0];
                imu_gbc_pkg::REG_NORM_TARGET:       norm_target_reg  <= cfg_data[15:0];
                imu_gbc_pkg::REG_NORM_TOLERANCE:    norm_tol_reg     <= cfg_data[15:0];
                imu_gbc_pkg::REG_BIAS_LIMIT:        bias_limit_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            norm_sum_reg  <= '0;
            nmax_reg      <= '0;
            nmin_reg      <= '0;
            abort_reg     <= 1'b0;
            pass_reg      <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                gsum_reg[k] <= '0;
                gmax_reg[k] <= '0;
                gmin_reg[k] <= '0;
                last_reg[k] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        acc_reg[0] <= accel_x;
                        acc_reg[1] <= accel_y;
                        acc_reg[2] <= accel_z;
                        gin_reg[0] <= gyro_x;
                        gin_reg[1] <= gyro_y;
                        gin_reg[2] <= gyro_z;
                        gok_reg    <= gyro_ok;
                        v_reg      <= '0;
                        cnt_reg    <= '0;
                        state_reg  <= ST_SQR;
                    end
                end
                ST_SQR:
                begin
                    v_reg <= v_reg + 32'(prod);
                    if (cnt_reg == 6'd2)
                    begin
                        cnt_reg   <= '0;
                        res_reg   <= '0;
                        bit_reg   <= 32'h4000_0000;
                        state_reg <= ST_ROOT;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                ST_ROOT:
                begin
                    if (v_reg >= trial)
                    begin
                        v_reg   <= v_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                        res_reg <= res_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    if (cnt_reg == 6'd15)
                        state_reg <= ST_UPD;
                    cnt_reg <= cnt_reg + 6'd1;
                end
                ST_UPD:
                begin
                    nmax_reg     <= nmax_new;
                    nmin_reg     <= nmin_new;
                    norm_sum_reg <= norm_sum_reg + {16'd0, norm};
                    idx_reg      <= idx_plus[15:0];
                    for (int k = 0; k < 3; k++)
                    begin
                        last_reg[k] <= lg_new[k];
                        gmax_reg[k] <= gmax_new[k];
                        gmin_reg[k] <= gmin_new[k];
                        if (gok_reg)
                            gsum_reg[k] <= gsum_reg[k] + 33'(gin_reg[k]);
                    end
                    if (done)
                    begin
                        abort_reg <= abort_now;
                        pass_reg  <= !abort_now;
                        k_reg     <= '0;
                        state_reg <= ST_CHK_NEXT;
                        cnt_reg   <= 6'd63;
                    end
                    else
                        state_reg <= ST_IDLE;
                end
                ST_DIV:
                begin
                    rem_reg <= rem_ge ? (rem_sh - {1'b0, den}) : rem_sh;
                    dq_reg  <= {dq_reg[39:0], rem_ge};
                    if (cnt_reg == 6'd40)
                        state_reg <= ST_CHK_NEXT;
                    cnt_reg <= cnt_reg + 6'd1;
                end
                ST_CHK_NEXT:
                begin
                    // first pass only loads the norm operand
                    if (cnt_reg == 6'd63)
                    begin
                        dq_reg    <= dividend;
                        neg_reg   <= mag_neg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        if (chk_fail)
                            pass_reg <= 1'b0;
                        if (k_reg == 2'd0)
                            mean_reg <= dq_reg[23:0];
                        else
                            bias_reg[k_reg - 2'd1] <= neg_reg ? 24'(-dq_reg[23:0])
                                                              : dq_reg[23:0];
                        if (k_reg == 2'd3)
                            state_reg <= ST_OUT;
                        else
                        begin
                            dq_reg    <= dividend;
                            neg_reg   <= mag_neg;
                            rem_reg   <= '0;
                            cnt_reg   <= '0;
                            k_reg     <= k_reg + 2'd1;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        passed_reg    <= pass_reg;
                        abort_out_reg <= abort_reg;
                        mean_out_reg  <= mean_reg;
                        for (int k = 0; k < 3; k++)
                            bias_out_reg[k] <= bias_reg[k];
                        idx_reg      <= '0;
                        norm_sum_reg <= '0;
                        nmax_reg     <= '0;
                        nmin_reg     <= '0;
                        for (int k = 0; k < 3; k++)
                        begin
                            gsum_reg[k] <= '0;
                            gmax_reg[k] <= '0;
                            gmin_reg[k] <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign passed        = passed_reg;
    assign aborted_early = abort_out_reg;
    assign bias_x        = bias_out_reg[0];
    assign bias_y        = bias_out_reg[1];
    assign bias_z        = bias_out_reg[2];
    assign mean_norm     = mean_out_reg;

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(passed && aborted_early))
        else $error("pass and early abort both set");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a request while busy");
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg <= 6'd40)
        else $error("divider step count overrun");
`endif

endmodule

// ----- test/tb.sv -----
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CycleLimit = 3000000;
    localparam int SettleCycles = 60;
    localparam int EndCycles = 300;

    typedef struct {
        imu_gbc_pkg::axis_t ax;
        imu_gbc_pkg::axis_t ay;
        imu_gbc_pkg::axis_t az;
        imu_gbc_pkg::axis_t gx;
        imu_gbc_pkg::axis_t gy;
        imu_gbc_pkg::axis_t gz;
        logic  ok;
    } sample_t;

    typedef struct {
        logic               passed;
        logic               aborted;
        logic signed [23:0] bx;
        logic signed [23:0] by;
        logic signed [23:0] bz;
        logic [23:0]        mn;
    } verdict_t;

    typedef struct {
        bit          is_write;
        logic [2:0]  idx;
        logic [22:0] val;
        sample_t     s;
        bit          typed;
        verdict_t    r;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [22:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    imu_gbc_pkg::axis_t accel_x = '0;
    imu_gbc_pkg::axis_t accel_y = '0;
    imu_gbc_pkg::axis_t accel_z = '0;
    imu_gbc_pkg::axis_t gyro_x = '0;
    imu_gbc_pkg::axis_t gyro_y = '0;
    imu_gbc_pkg::axis_t gyro_z = '0;
    logic gyro_ok = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic passed;
    logic aborted_early;
    logic signed [23:0] bias_x;
    logic signed [23:0] bias_y;
    logic signed [23:0] bias_z;
    logic [23:0] mean_norm;

    int unsigned send_idle = 6;
    int unsigned recv_idle = 64;
    int unsigned cycles = 0;
    int unsigned failures = 0;
    verdict_t verdict_q[$];
    row_t plan[$];

    int unsigned win_len;
    int unsigned norm_spread_max;
    int unsigned gyro_spread_max;
    int unsigned gravity_norm;
    int unsigned gravity_tol;
    int unsigned bias_max;
    int unsigned win_index;
    bit [31:0] norm_acc;
    longint gyro_acc[3];
    int unsigned norm_hi;
    int unsigned norm_lo;
    int gyro_hi[3];
    int gyro_lo[3];
    int held_gyro[3];

    imu_gyro_bias_calibrator uut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int unsigned int_sqrt(int unsigned v);
        int unsigned res;
        int unsigned bitv;
        res = 0;
        bitv = 32'h4000_0000;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint round_q8(longint num, int unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q = ((mag << 8) + longint'(den / 2)) / longint'(den);
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic void clear_window();
        win_index = 0;
        norm_acc = 0;
        norm_hi = 0;
        norm_lo = 0;
        for (int k = 0; k < 3; k++)
        begin
            gyro_acc[k] = 0;
            gyro_hi[k] = 0;
            gyro_lo[k] = 0;
        end
    endfunction

    function automatic void calib_reset();
        win_len = imu_gbc_pkg::RST_SAMPLE_COUNT;
        norm_spread_max = imu_gbc_pkg::RST_NORM_SPREAD_LIMIT;
        gyro_spread_max = imu_gbc_pkg::RST_GYRO_SPREAD_LIMIT;
        gravity_norm = imu_gbc_pkg::RST_NORM_TARGET;
        gravity_tol = imu_gbc_pkg::RST_NORM_TOLERANCE;
        bias_max = imu_gbc_pkg::RST_BIAS_LIMIT;
        clear_window();
        for (int k = 0; k < 3; k++)
            held_gyro[k] = 0;
    endfunction

    function automatic void calib_config(logic [2:0] idx, logic [22:0] val);
        case (idx)
            imu_gbc_pkg::REG_SAMPLE_COUNT:      win_len = val[15:0];
            imu_gbc_pkg::REG_NORM_SPREAD_LIMIT: norm_spread_max = val[15:0];
            imu_gbc_pkg::REG_GYRO_SPREAD_LIMIT: gyro_spread_max = val[15:0];
            imu_gbc_pkg::REG_NORM_TARGET:       gravity_norm = val[15:0];
            imu_gbc_pkg::REG_NORM_TOLERANCE:    gravity_tol = val[15:0];
            imu_gbc_pkg::REG_BIAS_LIMIT:        bias_max = val;
            default: ;
        endcase
    endfunction

    function automatic bit calib_step(sample_t s, output verdict_t r);
        int a[3];
        int g[3];
        int unsigned sq;
        int unsigned nrm;
        int unsigned cnt;
        bit abort;
        longint mean;
        longint dev;
        longint b[3];
        a[0] = s.ax;
        a[1] = s.ay;
        a[2] = s.az;
        g[0] = s.gx;
        g[1] = s.gy;
        g[2] = s.gz;
        sq = 0;
        for (int k = 0; k < 3; k++)
            sq = sq + int'(a[k] * a[k]);
        nrm = int_sqrt(sq);
        if (s.ok)
            for (int k = 0; k < 3; k++)
            begin
                held_gyro[k] = g[k];
                gyro_acc[k] = gyro_acc[k] + g[k];
            end
        norm_acc = norm_acc + nrm;
        if (win_index == 0)
        begin
            norm_hi = nrm;
            norm_lo = nrm;
            for (int k = 0; k < 3; k++)
            begin
                gyro_hi[k] = held_gyro[k];
                gyro_lo[k] = held_gyro[k];
            end
        end
        else
        begin
            if (nrm > norm_hi) norm_hi = nrm;
            if (nrm < norm_lo) norm_lo = nrm;
            for (int k = 0; k < 3; k++)
            begin
                if (held_gyro[k] > gyro_hi[k]) gyro_hi[k] = held_gyro[k];
                if (held_gyro[k] < gyro_lo[k]) gyro_lo[k] = held_gyro[k];
            end
        end
        abort = (norm_hi - norm_lo) > norm_spread_max;
        for (int k = 0; k < 3; k++)
            if (unsigned'(gyro_hi[k] - gyro_lo[k]) > gyro_spread_max)
                abort = 1;
        cnt = (win_len == 0) ? 1 : win_len;
        win_index++;
        if (!abort && win_index < cnt)
            return 0;
        mean = round_q8(longint'(norm_acc), cnt);
        r.passed = !abort;
        dev = mean - longint'(gravity_norm) * 256;
        if (dev < 0) dev = -dev;
        if (dev > longint'(gravity_tol) * 256) r.passed = 0;
        for (int k = 0; k < 3; k++)
        begin
            b[k] = round_q8(gyro_acc[k], cnt);
            dev = (b[k] < 0) ? -b[k] : b[k];
            if (dev > longint'(bias_max)) r.passed = 0;
        end
        r.aborted = abort;
        r.bx = b[0][23:0];
        r.by = b[1][23:0];
        r.bz = b[2][23:0];
        r.mn = mean[23:0];
        clear_window();
        return 1;
    endfunction

    function automatic sample_t mk(int ax, int ay, int az, int gx, int gy, int gz,
                                   logic ok);
        sample_t s;
        s.ax = ax[15:0];
        s.ay = ay[15:0];
        s.az = az[15:0];
        s.gx = gx[15:0];
        s.gy = gy[15:0];
        s.gz = gz[15:0];
        s.ok = ok;
        return s;
    endfunction

    function automatic verdict_t mkv(logic p, logic ab, int bx, int by, int bz, int mn);
        verdict_t r;
        r.passed = p;
        r.aborted = ab;
        r.bx = bx[23:0];
        r.by = by[23:0];
        r.bz = bz[23:0];
        r.mn = mn[23:0];
        return r;
    endfunction

    function automatic void add_write(logic [2:0] idx, int unsigned val);
        row_t w;
        w.is_write = 1;
        w.idx = idx;
        w.val = val[22:0];
        w.typed = 0;
        plan.push_back(w);
    endfunction

    function automatic void add_item(sample_t s);
        row_t w;
        w.is_write = 0;
        w.s = s;
        w.typed = 0;
        plan.push_back(w);
    endfunction

    function automatic void add_known(sample_t s, verdict_t r);
        row_t w;
        w.is_write = 0;
        w.s = s;
        w.typed = 1;
        w.r = r;
        plan.push_back(w);
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic sample_t still_sample(int unsigned tgt, int gb[3]);
        sample_t s;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(1));
        s = mk(jitter(30), jitter(30), int'(tgt) + jitter(20),
               gb[0] + jitter(30), gb[1] + jitter(30), gb[2] + jitter(30), 1'b1);
        if (pick < 16)
            s.ok = 1'b0;
        if (pick < 13)
        begin
            s.gx = $urandom;
            s.gy = $urandom;
            s.gz = $urandom;
        end
        return s;
    endfunction

    task automatic send_sample(sample_t s);
        verdict_t r;
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1'b1;
        accel_x <= s.ax;
        accel_y <= s.ay;
        accel_z <= s.az;
        gyro_x <= s.gx;
        gyro_y <= s.gy;
        gyro_z <= s.gz;
        gyro_ok <= s.ok;
        do
            @(posedge clk);
        while (!in_ready);
        if (calib_step(s, r))
            verdict_q.push_back(r);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [22:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        calib_config(idx, val);
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        verdict_t e;
        if (out_valid && out_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result with none expected");
                failures++;
            end
            else
            begin
                e = verdict_q.pop_front();
                if (passed !== e.passed)
                begin
                    $error("passed exp %0d got %0d", e.passed, passed);
                    failures++;
                end
                if (aborted_early !== e.aborted)
                begin
                    $error("aborted_early exp %0d got %0d", e.aborted, aborted_early);
                    failures++;
                end
                if (bias_x !== e.bx)
                begin
                    $error("bias_x exp %0d got %0d", e.bx, bias_x);
                    failures++;
                end
                if (bias_y !== e.by)
                begin
                    $error("bias_y exp %0d got %0d", e.by, bias_y);
                    failures++;
                end
                if (bias_z !== e.bz)
                begin
                    $error("bias_z exp %0d got %0d", e.bz, bias_z);
                    failures++;
                end
                if (mean_norm !== e.mn)
                begin
                    $error("mean_norm exp %0d got %0d", e.mn, mean_norm);
                    failures++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle);
    end

    initial
    begin
        verdict_t r;
        int gb[3];
        int unsigned phase_cfg[6][6];
        int unsigned phase_len[6];
        int unsigned tgt;

        calib_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_write(imu_gbc_pkg::REG_SAMPLE_COUNT, 1);
        add_known(mk(0, 0, 0, 0, 0, 0, 1), mkv(0, 0, 0, 0, 0, 0));
        add_known(mk(5461, 0, 0, 0, 0, 0, 1), mkv(1, 0, 0, 0, 0, 1398016));
        add_known(mk(-32768, -32768, -32768, -32768, -32768, -32768, 1),
                  mkv(0, 0, -8388608, -8388608, -8388608, 14529280));
        add_known(mk(32767, 32767, 32767, 32767, 32767, 32767, 1),
                  mkv(0, 0, 8388352, 8388352, 8388352, 14529024));
        add_known(mk(5461, 0, 0, -5, 77, 1234, 0), mkv(1, 0, 0, 0, 0, 1398016));
        add_write(imu_gbc_pkg::REG_SAMPLE_COUNT, 0);
        add_known(mk(0, 0, -5461, 9, -9, 0, 1), mkv(1, 0, 2304, -2304, 0, 1398016));
        add_write(imu_gbc_pkg::REG_SAMPLE_COUNT, 4);
        add_item(mk(5461, 0, 0, 0, 0, 0, 1));
        add_item(mk(5461, 0, 0, 141, 0, 0, 1));
        add_item(mk(5461, 0, 0, 141, 0, 0, 1));
        add_item(mk(5461, 0, 0, 0, 0, 0, 1));
        add_item(mk(5461, 0, 0, 0, 0, 0, 1));
        add_item(mk(5461, 0, 0, 142, 0, 0, 1));
        add_item(mk(0, 5461, 0, -900, 300, 7, 0));
        add_item(mk(0, 5461, 0, 32767, -32768, 1, 0));
        add_item(mk(0, 5461, 0, 142, 0, 0, 1));
        add_item(mk(0, 5461, 0, 142, 0, 0, 1));
        add_write(imu_gbc_pkg::REG_NORM_SPREAD_LIMIT, 0);
        add_item(mk(100, 0, 0, 142, 0, 0, 1));
        add_item(mk(101, 0, 0, 142, 0, 0, 1));
        add_write(imu_gbc_pkg::REG_NORM_TARGET, 100);
        add_write(imu_gbc_pkg::REG_NORM_TOLERANCE, 0);
        add_write(imu_gbc_pkg::REG_BIAS_LIMIT, 0);
        add_write(imu_gbc_pkg::REG_SAMPLE_COUNT, 2);
        add_item(mk(100, 0, 0, 0, 0, 0, 1));
        add_item(mk(0, -100, 0, 0, 0, 0, 1));
        add_write(imu_gbc_pkg::REG_GYRO_SPREAD_LIMIT, 65535);
        add_write(imu_gbc_pkg::REG_NORM_SPREAD_LIMIT, 65535);
        add_write(imu_gbc_pkg::REG_SAMPLE_COUNT, 4);
        add_item(mk(100, 0, 0, 3, 0, 0, 1));
        add_item(mk(90, 0, 0, 0, 2, 0, 1));
        add_write(imu_gbc_pkg::REG_SAMPLE_COUNT, 1);
        add_item(mk(100, 0, 0, 0, 0, 1, 1));

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                settle();
                write_reg(plan[i].idx, plan[i].val);
            end
            else if (plan[i].typed)
            begin
                send_sample(plan[i].s);
                void'(verdict_q.pop_back());
                verdict_q.push_back(plan[i].r);
            end
            else
                send_sample(plan[i].s);
        end

        phase_cfg = '{
            '{$urandom_range(8, 4), 390, 141, 5461, 279, 2403},
            '{0, 65535, 65535, 65535, 65535, 8388607},
            '{65535, 0, 0, 0, 0, 0},
            '{$urandom_range(6, 2), $urandom_range(400, 50), $urandom_range(200, 30),
              5461, $urandom_range(400, 100), $urandom_range(4000, 500)},
            '{1, 390, 141, 16384, 279, 2403},
            '{$urandom_range(10, 3), 390, 141, 5461, 279, 2403}};
        phase_len = '{320, 300, 250, 350, 300, 380};

        for (int p = 0; p < 6; p++)
        begin
            settle();
            if (p == 2)
            begin
                send_idle = 64;
                recv_idle = 6;
            end
            else if (p == 4)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            for (int k = 0; k < 6; k++)
                write_reg(3'(k), 23'(phase_cfg[p][k]));
            tgt = (gravity_norm <= 30000) ? gravity_norm : 5461;
            for (int k = 0; k < 3; k++)
                gb[k] = jitter(12);
            for (int n = 0; n < phase_len[p]; n++)
                send_sample(still_sample(tgt, gb));
        end

        in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (EndCycles) @(posedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/imu_gbc_pkg.sv
hdl/imu_gyro_bias_calibrator.sv
test/tb.sv
